// File: hw/rtl/wildcard_motif_min_mismatch_scan_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the wildcard motif scan core
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_MOTIF_MIN_MISMATCH_SCAN_CORE_MACROS_SVH
`define WILDCARD_MOTIF_MIN_MISMATCH_SCAN_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Plain property check.
`define WMMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define WMMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define WMMS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WMMS_ASSERT(lbl, prop, msg)
`define WMMS_ASSERT_IMP(lbl, ante, cons, msg)
`define WMMS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/wmms_pkg.sv
// ---------------------------------------------------------------------------
// Wildcard motif scan package
// Shared widths, register indexes, reset values, the motif configuration
// type and the motif length clamp.
// ---------------------------------------------------------------------------
package wmms_pkg;

    // Default parameter values.
    localparam int MOTIF_MAX_DEF   = 32;
    localparam int SEQ_LEN_MAX_DEF = 8192;

    // Field widths fixed by the interface.
    localparam int BASE_W     = 3;
    localparam int CODES_W    = 64;
    localparam int CARE_W     = 32;
    localparam int LEN_W      = 6;
    localparam int LEAST_W    = 6;
    localparam int SEEN_W     = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Base codes.
    localparam logic [BASE_W-1:0] BASE_OTHER = 3'd4;

    // Saturation points.
    localparam logic [SEEN_W-1:0]  SEEN_CAP  = 14'h3FFF;
    localparam logic [LEAST_W-1:0] LIMIT_CAP = 6'd32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MOTIF_CODES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOTIF_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_LIMIT  = 2'd3;

    // Configuration reset values.
    localparam logic [CODES_W-1:0] MOTIF_CODES_RST  = '0;
    localparam logic [CARE_W-1:0]  CARE_MASK_RST    = '1;
    localparam logic [LEN_W-1:0]   MOTIF_LENGTH_RST = 6'd8;
    localparam logic [LEAST_W-1:0] START_LIMIT_RST  = 6'd32;

    // Motif description handed to the window compare.
    typedef struct packed {
        logic [CODES_W-1:0] motif_codes;
        logic [CARE_W-1:0]  care_mask;
        logic [LEN_W-1:0]   motif_length;
    } motif_cfg_t;

    // Length in use: zero counts as one, anything above the window depth
    // counts as the window depth.
    function automatic logic [LEN_W-1:0] clamp_len(
        input logic [LEN_W-1:0] len,
        input logic [LEN_W-1:0] len_max
    );
        logic [LEN_W-1:0] m;
        begin
            m = len;
            if (m == '0)
            begin
                m = 6'd1;
            end
            if (m > len_max)
            begin
                m = len_max;
            end
            return m;
        end
    endfunction

endpackage

// File: hw/rtl/wmms_cmp.sv
// ---------------------------------------------------------------------------
// Wildcard motif window compare
// Counts mismatches between the base window and the motif at cared positions.
// ---------------------------------------------------------------------------
module wmms_cmp #(
    parameter int MOTIF_MAX = wmms_pkg::MOTIF_MAX_DEF
) (
    input  logic [MOTIF_MAX-1:0][wmms_pkg::BASE_W-1:0] window,
    input  wmms_pkg::motif_cfg_t                        cfg,
    output logic [$clog2(MOTIF_MAX+1)-1:0]              count
);

    localparam int PW = $clog2(MOTIF_MAX);
    localparam int CW = $clog2(MOTIF_MAX+1);

    logic [wmms_pkg::LEN_W-1:0] m_act;
    logic [MOTIF_MAX-1:0]       miss;

    assign m_act = wmms_pkg::clamp_len(cfg.motif_length,
                                       wmms_pkg::LEN_W'(MOTIF_MAX));

    // Window entry j (newest first) lines up with motif position m-1-j.
    for (genvar j = 0; j < MOTIF_MAX; j++)
    begin : g_lane
        logic [PW-1:0] pos;
        logic [1:0]    want;
        logic          care;

        assign pos  = PW'(m_act - wmms_pkg::LEN_W'(j + 1));
        assign want = cfg.motif_codes[{pos, 1'b0} +: 2];
        assign care = cfg.care_mask[pos];
        assign miss[j] = (wmms_pkg::LEN_W'(j) < m_act) && care &&
                         (window[j][2] || (window[j][1:0] != want));
    end

    assign count = CW'($countones(miss));

endmodule

// File: hw/rtl/wildcard_motif_min_mismatch_scan_core.sv
// ---------------------------------------------------------------------------
// Wildcard motif minimum mismatch scan core
// Streams a DNA sequence against a motif with don't-care positions and
// reports the least window mismatch count and how many windows reach it.
// ---------------------------------------------------------------------------
// Throughput: one base per cycle while in_stall is low, set by the
// three-stage pipeline. Result path: the last base of a sequence passes
// the stage 1, stage 2 and output registers before the result appears.
// Reset: rst_n clears the pipeline valid flags, the sequence state and
// out_valid, and loads the register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
//
// Pipeline:
//   Accept     The base (codes above four folded to "other") shifts into the
//              window register, the base counter advances and flags mark the
//              first base, the last base and whether a full window exists.
//   Compare    wmms_cmp lines the motif up with the window and counts the
//              cared mismatches; the count is registered.
//   Update     The count is folded into the running least and tie count. On
//              the last base the result goes to the output register and the
//              sequence state reloads from the start limit.
//
// Only a last-base transaction needs the output register, so the pipeline
// keeps taking bases while a result waits; it backs up only when a last base
// reaches the update stage and the output is still occupied and stalled.
// Configuration writes land directly in the registers and the compare reads
// them combinationally, so a write also applies to bases already in the pipeline.

`include "wildcard_motif_min_mismatch_scan_core_macros.svh"

module wildcard_motif_min_mismatch_scan_core #(
    parameter int MOTIF_MAX   = wmms_pkg::MOTIF_MAX_DEF,
    parameter int SEQ_LEN_MAX = wmms_pkg::SEQ_LEN_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [wmms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wmms_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    // Base stream.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [wmms_pkg::BASE_W-1:0]         base,
    input  logic                                last,

    // Result stream.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [wmms_pkg::LEAST_W-1:0]        least_mismatches,
    output logic [$clog2(SEQ_LEN_MAX+1)-1:0]    window_count
);

    localparam int CW = $clog2(MOTIF_MAX+1);
    localparam int TW = $clog2(SEQ_LEN_MAX+1);

    localparam logic [TW-1:0] TIES_CAP = TW'(SEQ_LEN_MAX);

    // Control flags that travel with a transaction down the pipeline.
    typedef struct packed {
        logic last;
        logic first;
        logic win;
    } stage_ctl_t;

    // Configuration registers.
    logic [wmms_pkg::CODES_W-1:0] motif_codes_reg;
    logic [wmms_pkg::CARE_W-1:0]  care_mask_reg;
    logic [wmms_pkg::LEN_W-1:0]   motif_length_reg;
    logic [wmms_pkg::LEAST_W-1:0] start_limit_reg;
    wmms_pkg::motif_cfg_t         motif_cfg;
    logic [wmms_pkg::LEN_W-1:0]   m_act;
    logic [wmms_pkg::LEAST_W-1:0] start_clamp;

    // Accept stage.
    logic [MOTIF_MAX-1:0][wmms_pkg::BASE_W-1:0] window_reg;
    logic [MOTIF_MAX-1:0][wmms_pkg::BASE_W-1:0] window_next;
    logic [wmms_pkg::SEEN_W-1:0] seen_reg;
    logic [wmms_pkg::SEEN_W-1:0] seen_next;
    logic [wmms_pkg::SEEN_W-1:0] seen_inc;
    logic [wmms_pkg::BASE_W-1:0] base_fold;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    stage_ctl_t                  s1_ctl_reg;
    stage_ctl_t                  s1_ctl_next;

    // Compare stage.
    logic [CW-1:0] cmp_count;
    logic          s2_valid_reg;
    logic          s2_valid_next;
    stage_ctl_t    s2_ctl_reg;
    logic [CW-1:0] s2_count_reg;

    // Update stage and output.
    logic [wmms_pkg::LEAST_W-1:0] least_reg;
    logic [wmms_pkg::LEAST_W-1:0] least_next;
    logic [TW-1:0]                ties_reg;
    logic [TW-1:0]                ties_next;
    logic [wmms_pkg::LEAST_W-1:0] least_upd;
    logic [TW-1:0]                ties_upd;
    logic [wmms_pkg::LEAST_W-1:0] count_ext;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [wmms_pkg::LEAST_W-1:0] out_least_reg;
    logic [TW-1:0]                out_ties_reg;

    // Handshake.
    logic in_acc;
    logic out_free;
    logic s1_go;
    logic s2_go;
    logic s2_ready;

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motif_codes_reg  <= wmms_pkg::MOTIF_CODES_RST;
            care_mask_reg    <= wmms_pkg::CARE_MASK_RST;
            motif_length_reg <= wmms_pkg::MOTIF_LENGTH_RST;
            start_limit_reg  <= wmms_pkg::START_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wmms_pkg::REG_MOTIF_CODES:
                begin
                    motif_codes_reg <= cfg_wdata;
                end
                wmms_pkg::REG_CARE_MASK:
                begin
                    care_mask_reg <= cfg_wdata[wmms_pkg::CARE_W-1:0];
                end
                wmms_pkg::REG_MOTIF_LENGTH:
                begin
                    motif_length_reg <= cfg_wdata[wmms_pkg::LEN_W-1:0];
                end
                wmms_pkg::REG_START_LIMIT:
                begin
                    start_limit_reg <= cfg_wdata[wmms_pkg::LEAST_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign motif_cfg.motif_codes  = motif_codes_reg;
    assign motif_cfg.care_mask    = care_mask_reg;
    assign motif_cfg.motif_length = motif_length_reg;

    assign m_act = wmms_pkg::clamp_len(motif_length_reg,
                                       wmms_pkg::LEN_W'(MOTIF_MAX));
    assign start_clamp = (start_limit_reg > wmms_pkg::LIMIT_CAP) ?
                         wmms_pkg::LIMIT_CAP : start_limit_reg;

    // -----------------------------------------------------------------------
    // Handshake: each stage moves when the one after it has room.
    // -----------------------------------------------------------------------
    assign out_free = !out_valid_reg || !out_stall;
    assign s2_go    = s2_valid_reg && (!s2_ctl_reg.last || out_free);
    assign s2_ready = !s2_valid_reg || s2_go;
    assign s1_go    = s1_valid_reg && s2_ready;
    assign in_stall = s1_valid_reg && !s2_ready;
    assign in_acc   = in_valid && !in_stall;

    // -----------------------------------------------------------------------
    // Accept stage
    // -----------------------------------------------------------------------
    assign base_fold = (base > wmms_pkg::BASE_OTHER) ? wmms_pkg::BASE_OTHER : base;
    assign seen_inc  = (seen_reg == wmms_pkg::SEEN_CAP) ?
                       seen_reg : seen_reg + wmms_pkg::SEEN_W'(1);

    always_comb
    begin
        window_next   = window_reg;
        seen_next     = seen_reg;
        s1_ctl_next   = s1_ctl_reg;
        s1_valid_next = s1_valid_reg;
        if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_acc)
        begin
            window_next       = {window_reg[MOTIF_MAX-2:0], base_fold};
            seen_next         = last ? '0 : seen_inc;
            s1_ctl_next.last  = last;
            s1_ctl_next.first = (seen_reg == '0);
            s1_ctl_next.win   = (seen_inc >= wmms_pkg::SEEN_W'(m_act));
            s1_valid_next     = 1'b1;
        end
    end

    // -----------------------------------------------------------------------
    // Compare stage: reads the window while its transaction sits in stage 1.
    // -----------------------------------------------------------------------
    wmms_cmp #(
        .MOTIF_MAX (MOTIF_MAX)
    ) u_cmp (
        .window (window_reg),
        .cfg    (motif_cfg),
        .count  (cmp_count)
    );

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s2_go)
        begin
            s2_valid_next = 1'b0;
        end
        if (s1_go)
        begin
            s2_valid_next = 1'b1;
        end
    end

    // -----------------------------------------------------------------------
    // Update stage: the first base of a sequence starts from the start
    // limit; for a full window a lower count replaces the least, an equal one adds a tie.
    // -----------------------------------------------------------------------
    assign count_ext = wmms_pkg::LEAST_W'(s2_count_reg);

    always_comb
    begin
        least_upd = s2_ctl_reg.first ? start_clamp : least_reg;
        ties_upd  = s2_ctl_reg.first ? '0 : ties_reg;
        if (s2_ctl_reg.win)
        begin
            if (count_ext == least_upd)
            begin
                if (ties_upd < TIES_CAP)
                begin
                    ties_upd = ties_upd + TW'(1);
                end
            end
            else if (count_ext < least_upd)
            begin
                least_upd = count_ext;
                ties_upd  = TW'(1);
            end
        end
    end

    always_comb
    begin
        least_next     = least_reg;
        ties_next      = ties_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (s2_go)
        begin
            if (s2_ctl_reg.last)
            begin
                least_next     = start_clamp;
                ties_next      = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                least_next = least_upd;
                ties_next  = ties_upd;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Control registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s1_ctl_reg    <= '0;
            s2_valid_reg  <= 1'b0;
            s2_ctl_reg    <= '0;
            least_reg     <= wmms_pkg::LIMIT_CAP;
            ties_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            s1_valid_reg  <= s1_valid_next;
            s1_ctl_reg    <= s1_ctl_next;
            s2_valid_reg  <= s2_valid_next;
            if (s1_go)
            begin
                s2_ctl_reg <= s1_ctl_reg;
            end
            least_reg     <= least_next;
            ties_reg      <= ties_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // -----------------------------------------------------------------------
    // Payload registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
        if (s1_go)
        begin
            s2_count_reg <= cmp_count;
        end
        if (s2_go && s2_ctl_reg.last)
        begin
            out_least_reg <= least_upd;
            out_ties_reg  <= ties_upd;
        end
    end

    assign out_valid        = out_valid_reg;
    assign least_mismatches = out_least_reg;
    assign window_count     = out_ties_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `WMMS_ASSERT(a_ties_cap, ties_reg <= TIES_CAP, "tie count above saturation point")
    `WMMS_ASSERT(a_least_cap, least_reg <= wmms_pkg::LIMIT_CAP, "least count above limit")
    `WMMS_ASSERT_NXT(a_accept_lands, in_acc, s1_valid_reg, "accepted base lost in stage 1")
    `WMMS_ASSERT_NXT(a_last_held, s2_valid_reg && s2_ctl_reg.last && !out_free, s2_valid_reg && s2_ctl_reg.last, "blocked last base dropped")

endmodule
